// ===== rtl/lrg4_pkg.sv =====
package lrg4_pkg;

  localparam int ScreenWidth  = 256;
  localparam int ScreenHeight = 32;
  localparam int RowStride    = 128;
  localparam int StoreDepth   = 4096;

  localparam int XW      = 10;
  localparam int YW      = 8;
  localparam int ColorW  = 4;
  localparam int AddrW   = $clog2(StoreDepth);
  localparam int DataW   = 8;
  localparam int RowShift = $clog2(RowStride);
  // error sums reach twice the longest span, the point counter span plus two
  localparam int AccW    = XW + 1;

  typedef enum logic {
    CmdDraw = 1'b0,
    CmdRead = 1'b1
  } cmd_kind_e;

  // classified command as it travels from front to back
  typedef struct packed {
    cmd_kind_e         kind;
    logic [XW-1:0]     x0;
    logic [YW-1:0]     y0;
    logic [XW-1:0]     dx;
    logic [YW-1:0]     dy;
    logic [XW-1:0]     span;
    logic              x_dn;
    logic              y_dn;
    logic [ColorW-1:0] color;
    logic [AddrW-1:0]  addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic clear_done;
  } back_status_t;

endpackage

// ===== rtl/lrg4_if.sv =====
interface lrg4_cmd_if;
  import lrg4_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [XW-1:0]     x_start;
  logic [YW-1:0]     y_start;
  logic [XW-1:0]     x_end;
  logic [YW-1:0]     y_end;
  logic [ColorW-1:0] pixel_color;
  logic [AddrW-1:0]  read_address;

  modport source (
    output valid, action, x_start, y_start, x_end, y_end, pixel_color, read_address,
    input  ready
  );
  modport sink (
    input  valid, action, x_start, y_start, x_end, y_end, pixel_color, read_address,
    output ready
  );
endinterface

interface lrg4_rsp_if;
  import lrg4_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ===== rtl/line_raster_gray4_framebuffer_core.sv =====
// Line rasterizer over a 4-bit gray framebuffer (two pixels per byte).
//
// Channels: cmd_i takes one item per command. action 0 draws a line from
// (x_start, y_start) to (x_end, y_end) in pixel_color, endpoints saturated
// at the screen edge; action 1 reads the byte at read_address and clears it.
// rsp_o returns read_data for every read, in command order; draws return
// nothing. Both use valid/ready; an item moves when both are high.
//
// Draws: a draw of span s (larger of the column and row distance)
// plots s+2 points, each a read-modify-write of one store byte through
// the single read and single write port. A read fetches its byte and
// then writes zero back; its result waits behind any draw still queued
// ahead of it.
//
// Reset: the store is swept to zero, one byte per cycle, all 4096 bytes;
// cmd_i.ready stays low until the sweep ends.
// Stall: a two-entry queue takes commands while the back end works. A
// result waiting on rsp_o holds the back end only at the next read.
module line_raster_gray4_framebuffer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrg4_cmd_if.sink   cmd_i,
  lrg4_rsp_if.source rsp_o
);
  import lrg4_pkg::*;

  logic         push;
  cmd_t         push_data;
  cmd_t         head;
  logic         pop;
  fifo_status_t fifo_status;
  back_status_t back_status;

  // classify and clamp each accepted item
  lrg4_front u_front (
    .cmd           (cmd_i),
    .fifo_status_i (fifo_status),
    .back_status_i (back_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // decouple acceptance from execution
  lrg4_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  // step lines, serve reads, own the store
  lrg4_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .status_o      (back_status),
    .rsp           (rsp_o)
  );

endmodule

// ===== rtl/lrg4_ram.sv =====
module lrg4_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrg4_cmd_fifo.sv =====
module lrg4_cmd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lrg4_pkg::cmd_t         push_data_i,
  input  logic                   pop_i,
  output lrg4_pkg::cmd_t         head_o,
  output lrg4_pkg::fifo_status_t status_o
);
  import lrg4_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.full  = (count_q == (PtrW+1)'(Depth));
  assign status_o.empty = (count_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("command queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty command queue");

endmodule

// ===== rtl/lrg4_front.sv =====
module lrg4_front (
  lrg4_cmd_if.sink                cmd,
  input  lrg4_pkg::fifo_status_t  fifo_status_i,
  input  lrg4_pkg::back_status_t  back_status_i,
  output logic                    push_o,
  output lrg4_pkg::cmd_t          push_data_o
);
  import lrg4_pkg::*;

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [XW-1:0] dx;
  logic [YW-1:0] dy;

  // saturate endpoints at the last column and row
  assign x0 = ({1'b0, cmd.x_start} >= (XW+1)'(ScreenWidth)) ? XW'(ScreenWidth - 1) : cmd.x_start;
  assign x1 = ({1'b0, cmd.x_end} >= (XW+1)'(ScreenWidth)) ? XW'(ScreenWidth - 1) : cmd.x_end;
  assign y0 = ({1'b0, cmd.y_start} >= (YW+1)'(ScreenHeight)) ? YW'(ScreenHeight - 1)
                                                             : cmd.y_start;
  assign y1 = ({1'b0, cmd.y_end} >= (YW+1)'(ScreenHeight)) ? YW'(ScreenHeight - 1)
                                                           : cmd.y_end;

  assign dx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
  assign dy = (y1 >= y0) ? (y1 - y0) : (y0 - y1);

  // hold off items until the store has been swept clean
  assign cmd.ready = !fifo_status_i.full && back_status_i.clear_done;
  assign push_o    = cmd.valid && cmd.ready;

  always_comb begin
    push_data_o.kind  = cmd.action ? CmdRead : CmdDraw;
    push_data_o.x0    = x0;
    push_data_o.y0    = y0;
    push_data_o.dx    = dx;
    push_data_o.dy    = dy;
    push_data_o.span  = (dx > XW'(dy)) ? dx : XW'(dy);
    push_data_o.x_dn  = (x1 < x0);
    push_data_o.y_dn  = (y1 < y0);
    push_data_o.color = cmd.pixel_color;
    push_data_o.addr  = cmd.read_address;
  end

endmodule

// ===== rtl/lrg4_back.sv =====
module lrg4_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lrg4_pkg::cmd_t          head_i,
  input  lrg4_pkg::fifo_status_t  fifo_status_i,
  output logic                    pop_o,
  output lrg4_pkg::back_status_t  status_o,
  lrg4_rsp_if.source              rsp
);
  import lrg4_pkg::*;

  typedef enum logic [5:0] {
    StClear  = 6'b000001,
    StIdle   = 6'b000010,
    StDrawRd = 6'b000100,
    StDrawWr = 6'b001000,
    StReadRd = 6'b010000,
    StReadWr = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  cmd_t cmd_q, cmd_d;
  logic [XW-1:0]   cx_q, cx_d;
  logic [YW-1:0]   cy_q, cy_d;
  logic [AccW-1:0] ex_q, ex_d;
  logic [AccW-1:0] ey_q, ey_d;
  logic [AccW-1:0] n_q, n_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  logic [AccW-1:0]  ex_sum, ey_sum, span_ext, last_n;
  logic [AddrW-1:0] pix_idx;
  logic [DataW-1:0] merged;
  logic             out_free;

  lrg4_ram #(
    .Width (DataW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign span_ext = AccW'(cmd_q.span);
  assign last_n   = span_ext + AccW'(1);
  assign ex_sum   = ex_q + AccW'(cmd_q.dx);
  assign ey_sum   = ey_q + AccW'(cmd_q.dy);
  // byte index wraps to the store size
  assign pix_idx  = AddrW'((32'(cy_q) << RowShift) + 32'(cx_q[XW-1:1]));
  assign merged   = cx_q[0] ? {ram_rdata[7:4], cmd_q.color} : {cmd_q.color, ram_rdata[3:0]};
  assign out_free = !out_valid_q || rsp.ready;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cmd_d       = cmd_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pix_idx;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = pix_idx;

    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(StoreDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (!fifo_status_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          cx_d  = head_i.x0;
          cy_d  = head_i.y0;
          ex_d  = '0;
          ey_d  = '0;
          n_d   = '0;
          state_d = (head_i.kind == CmdRead) ? StReadRd : StDrawRd;
        end
      end
      StDrawRd: begin
        ram_re  = 1'b1;
        state_d = StDrawWr;
      end
      StDrawWr: begin
        ram_we    = 1'b1;
        ram_wdata = merged;
        ex_d = ex_sum;
        ey_d = ey_sum;
        if (ex_sum > span_ext) begin
          ex_d = ex_sum - span_ext;
          cx_d = cmd_q.x_dn ? (cx_q - XW'(1)) : (cx_q + XW'(1));
        end
        if (ey_sum > span_ext) begin
          ey_d = ey_sum - span_ext;
          cy_d = cmd_q.y_dn ? (cy_q - YW'(1)) : (cy_q + YW'(1));
        end
        n_d     = n_q + AccW'(1);
        state_d = (n_q == last_n) ? StIdle : StDrawRd;
      end
      StReadRd: begin
        ram_re    = 1'b1;
        ram_raddr = cmd_q.addr;
        state_d   = StReadWr;
      end
      StReadWr: begin
        // wait for the output slot, then deliver and clear the byte
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = ram_rdata;
          ram_we      = 1'b1;
          ram_waddr   = cmd_q.addr;
          ram_wdata   = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    ex_q       <= ex_d;
    ey_q       <= ey_d;
    n_q        <= n_d;
    out_data_q <= out_data_d;
  end

  assign status_o.clear_done = (state_q != StClear);
  assign rsp.valid           = out_valid_q;
  assign rsp.read_data       = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !out_valid_q && !pop_o)
    else $error("activity during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StReadWr))
    else $error("result raised outside read completion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDrawWr |-> n_q <= last_n && ex_q <= span_ext && ey_q <= span_ext)
    else $error("line stepper out of range");

endmodule

// ===== tb/lrg4_fb_checker.sv =====
module lrg4_fb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lrg4_cmd_if  cmd_i,
  lrg4_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import lrg4_pkg::*;

  // shadow copy of the framebuffer and the bytes owed to reads, oldest first
  logic [DataW-1:0] shadow_fb [StoreDepth];
  logic [DataW-1:0] read_bytes_due [$];
  logic [DataW-1:0] due_byte;
  int               due_idx;

  function automatic int saturate(input int v, input int lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  task automatic plot_pixel(input int col, input int row, input logic [ColorW-1:0] shade);
    int c;
    int r;
    int idx;
    c   = saturate(col, ScreenWidth);
    r   = saturate(row, ScreenHeight);
    idx = (r * RowStride + c / 2) % StoreDepth;
    if (c % 2 == 1) begin
      shadow_fb[idx][3:0] = shade;
    end else begin
      shadow_fb[idx][7:4] = shade;
    end
  endtask

  // step along the major axis; span+2 points, first one repeated
  task automatic rasterize_line(input int xa, input int ya, input int xb, input int yb,
                                input logic [ColorW-1:0] shade);
    int x0, y0, x1, y1;
    int dx, dy, sx, sy;
    int span, ex, ey, cx, cy;
    x0 = saturate(xa, ScreenWidth);
    y0 = saturate(ya, ScreenHeight);
    x1 = saturate(xb, ScreenWidth);
    y1 = saturate(yb, ScreenHeight);
    dx = x1 - x0;
    dy = y1 - y0;
    sx = 0;
    sy = 0;
    if (dx > 0) begin
      sx = 1;
    end else if (dx < 0) begin
      sx = -1;
      dx = -dx;
    end
    if (dy > 0) begin
      sy = 1;
    end else if (dy < 0) begin
      sy = -1;
      dy = -dy;
    end
    span = (dx > dy) ? dx : dy;
    ex = 0;
    ey = 0;
    cx = x0;
    cy = y0;
    for (int n = 0; n <= span + 1; n++) begin
      plot_pixel((cx < 0) ? 0 : cx, (cy < 0) ? 0 : cy, shade);
      ex += dx;
      ey += dy;
      if (ex > span) begin
        ex -= span;
        cx += sx;
      end
      if (ey > span) begin
        ey -= span;
        cy += sy;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) shadow_fb[i] = '0;
      read_bytes_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // retire a result first; no read can come back in its own cycle
      if (rsp_i.valid && rsp_i.ready) begin
        if (read_bytes_due.size() == 0) begin
          $error("read_data 0x%02h arrived with no read outstanding", rsp_i.read_data);
          fail_count_o++;
        end else begin
          due_byte = read_bytes_due.pop_front();
          if (rsp_i.read_data !== due_byte) begin
            $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                   due_byte, rsp_i.read_data);
            fail_count_o++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        if (cmd_kind_e'(cmd_i.action) == CmdRead) begin
          due_idx = int'(cmd_i.read_address);
          read_bytes_due.push_back(shadow_fb[due_idx]);
          shadow_fb[due_idx] = '0;
        end else begin
          rasterize_line(int'(cmd_i.x_start), int'(cmd_i.y_start),
                         int'(cmd_i.x_end), int'(cmd_i.y_end), cmd_i.pixel_color);
        end
      end
      pending_o = read_bytes_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import lrg4_pkg::*;

  localparam int ItemTarget  = 1350;
  localparam int IdleLimit   = 20000;  // covers the clearing sweep
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 64;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_reads;
  int   items_sent;
  int   idle_cycles;
  logic steady;     // no gaps and no stalls on either side while high
  logic hold_rsp;   // ask the response side for one long hold-off
  logic held;
  logic paused;

  lrg4_cmd_if cmd_ch ();
  lrg4_rsp_if rsp_ch ();

  line_raster_gray4_framebuffer_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_ch),
    .rsp_o  (rsp_ch)
  );

  lrg4_fb_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_reads)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Byte index of a pixel after saturating it to the screen; used to aim
  // reads at pixels that a line just touched.
  function automatic int byte_of(input int col, input int row);
    int c;
    int r;
    c = (col >= ScreenWidth) ? ScreenWidth - 1 : col;
    r = (row >= ScreenHeight) ? ScreenHeight - 1 : row;
    return (r * RowStride + c / 2) % StoreDepth;
  endfunction

  // Offer one item at the falling edge and hold it until it is taken.
  // Idle first now and then, except in the steady window.
  task automatic send_cmd(input cmd_kind_e kind, input int xs, input int ys, input int xe,
                          input int ye, input int color, input int addr);
    if (!steady && $urandom_range(99) < 17) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    cmd_ch.valid        = 1'b1;
    cmd_ch.action       = kind;
    cmd_ch.x_start      = xs[XW-1:0];
    cmd_ch.y_start      = ys[YW-1:0];
    cmd_ch.x_end        = xe[XW-1:0];
    cmd_ch.y_end        = ye[YW-1:0];
    cmd_ch.pixel_color  = color[ColorW-1:0];
    cmd_ch.read_address = addr[AddrW-1:0];
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Draws carry a random read_address, reads random coordinates and color:
  // those fields must be ignored.
  task automatic draw_line(input int xs, input int ys, input int xe, input int ye,
                           input int color);
    send_cmd(CmdDraw, xs, ys, xe, ye, color, $urandom_range(StoreDepth - 1));
  endtask

  task automatic read_byte(input int addr);
    send_cmd(CmdRead, $urandom_range(1023), $urandom_range(255), $urandom_range(1023),
             $urandom_range(255), $urandom_range(15), addr);
  endtask

  // Stop offering items until every read has come back.
  task automatic drain_reads();
    cmd_ch.valid = 1'b0;
    while (pending_reads != 0) @(negedge clk);
  endtask

  // Response side: random stalls, none in the steady window, and one long
  // hold-off on request so that the command queue backs up.
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready = steady || ($urandom_range(99) >= 17);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int xs, ys, xe, ye, color, pick, probes;
    rst_n               = 1'b0;
    steady              = 1'b0;
    hold_rsp            = 1'b0;
    held                = 1'b0;
    paused              = 1'b0;
    items_sent          = 0;
    idle_cycles         = 0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.action       = CmdDraw;
    cmd_ch.x_start      = '0;
    cmd_ch.y_start      = '0;
    cmd_ch.x_end        = '0;
    cmd_ch.y_end        = '0;
    cmd_ch.pixel_color  = '0;
    cmd_ch.read_address = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    // Single point: equal endpoints write the same nibble twice.
    draw_line(5, 3, 5, 3, 4'hA);
    read_byte(byte_of(5, 3));
    // Both endpoints far off screen saturate to the last column and row.
    draw_line(1023, 255, 1023, 255, 4'hF);
    read_byte(StoreDepth - 1);
    // Short horizontal run across four bytes, both nibbles of each.
    draw_line(0, 0, 7, 0, 4'h5);
    for (int i = 0; i < 4; i++) read_byte(i);
    // Steep line over the whole height.
    draw_line(2, 0, 3, 31, 4'hC);
    read_byte(byte_of(2, 0));
    read_byte(byte_of(3, 31));
    // Both axes stepping down.
    draw_line(20, 10, 10, 5, 4'h9);
    read_byte(byte_of(20, 10));
    read_byte(byte_of(10, 5));
    // Longest span, end column saturated.
    draw_line(0, 31, 1023, 0, 4'h3);
    read_byte(byte_of(0, 31));
    read_byte(byte_of(255, 0));
    // Read a byte that was just cleared.
    read_byte(byte_of(255, 0));
    // Color zero over a mixed off-screen line.
    draw_line(600, 40, 0, 200, 4'h0);
    read_byte(byte_of(255, 31));
    // Overwrite one nibble of a byte and leave its neighbor alone.
    draw_line(3, 1, 3, 1, 4'hE);
    draw_line(2, 1, 2, 1, 4'h6);
    read_byte(byte_of(3, 1));
    drain_reads();

    // Random part: mostly a short line followed by reads aimed at it.
    while (items_sent < ItemTarget) begin
      steady = (items_sent >= 800 && items_sent < 1000);
      if (!held && items_sent >= 300) begin
        // hold the response side while reads keep coming, filling the queue
        held     = 1'b1;
        hold_rsp = 1'b1;
        repeat (30) read_byte($urandom_range(StoreDepth - 1));
      end
      if (!paused && items_sent >= 650) begin
        paused = 1'b1;
        drain_reads();
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: any field value at all
        if ($urandom_range(1) == 1) begin
          read_byte($urandom_range(StoreDepth - 1));
        end else begin
          draw_line($urandom_range(1023), $urandom_range(255), $urandom_range(1023),
                    $urandom_range(255), $urandom_range(15));
        end
      end else begin
        if (pick < 15) begin
          // a few long lines anywhere
          xs = $urandom_range(1023);
          ys = $urandom_range(255);
          xe = $urandom_range(1023);
          ye = $urandom_range(255);
        end else begin
          // short line, now and then starting off screen
          xs = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(ScreenWidth - 1);
          ys = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(ScreenHeight - 1);
          xe = xs + int'($urandom_range(24)) - 12;
          ye = ys + int'($urandom_range(16)) - 8;
          xe = (xe < 0) ? 0 : ((xe > 1023) ? 1023 : xe);
          ye = (ye < 0) ? 0 : ((ye > 255) ? 255 : ye);
        end
        color = $urandom_range(15);
        draw_line(xs, ys, xe, ye, color);
        probes = $urandom_range(3);
        for (int i = 0; i < probes; i++) begin
          case ($urandom_range(2))
            0: read_byte(byte_of(xs, ys));
            1: read_byte(byte_of(xe, ye));
            default: read_byte(byte_of((xs + xe) / 2, (ys + ye) / 2));
          endcase
        end
      end
    end
    steady = 1'b0;

    // Drop valid, collect every outstanding read, then watch a while longer
    // for anything unexpected.
    drain_reads();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
